FILE: sv/mmst_pkg.sv
// ----------------------------------------------------------------------------
// mmst_pkg
// Shared types and constants for the multi-mode session timer.
// ----------------------------------------------------------------------------
package mmst_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StampW  = 32;
  localparam int unsigned CountW  = 8;

  localparam logic [StampW-1:0] TickMs     = 32'd1000;
  localparam int unsigned       LongEvery  = 4;

  localparam logic [CfgW-1:0] FocusRst     = 16'd1500;
  localparam logic [CfgW-1:0] ShortRst     = 16'd300;
  localparam logic [CfgW-1:0] LongRst      = 16'd900;
  localparam logic [CfgW-1:0] CountdownRst = 16'd60;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_RESET = 3'd3,
    FUNC_NEXT  = 3'd4,
    FUNC_MODE  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    MODE_SESSION   = 2'd0,
    MODE_COUNTDOWN = 2'd1,
    MODE_STOPWATCH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_FOCUS = 2'd0,
    PHASE_SHORT = 2'd1,
    PHASE_LONG  = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FOCUS     = 2'd0,
    REG_SHORT     = 2'd1,
    REG_LONG      = 2'd2,
    REG_COUNTDOWN = 2'd3
  } reg_idx_e;

endpackage

FILE: sv/multi_mode_session_timer.sv
// ----------------------------------------------------------------------------
// multi_mode_session_timer
// Session cycle, countdown and stopwatch timer driven by event transactions.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   func_i, now_ms_i, new_mode_i
//  out      output     out_valid_o / out_stall_i mode_o, phase_o, running_o,
//                                                shown_value_o, sessions_done_o,
//                                                alarm_o, refresh_o
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  one event per clock unless in_stall_o holds it; its result is in the output register in the next cycle
//  the event logic (32-bit elapsed compare, decrements and increments) is the
//  only path between the timer state and the result register
//  in_stall_o is high only while a held result is itself stalled
//  reset clears state, loads the register defaults and empties the output
// ----------------------------------------------------------------------------
module multi_mode_session_timer
  import mmst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [StampW-1:0]  now_ms_i,
  input  logic [1:0]         new_mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         mode_o,
  output logic [1:0]         phase_o,
  output logic               running_o,
  output logic [31:0]        shown_value_o,
  output logic [CountW-1:0]  sessions_done_o,
  output logic               alarm_o,
  output logic               refresh_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [CfgW-1:0] focus_len_q, short_len_q, long_len_q, cd_len_q;

  logic              run_q, run_d;
  mode_e             mode_q, mode_d;
  phase_e            phase_q, phase_d;
  logic [CfgW-1:0]   session_left_q, session_left_d;
  logic [CountW-1:0] focus_cnt_q, focus_cnt_d;
  logic [CfgW-1:0]   cd_left_q, cd_left_d;
  logic [31:0]       elapsed_q, elapsed_d;
  logic [StampW-1:0] last_ms_q, last_ms_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  mode_out_q, phase_out_q;
  logic        running_q, alarm_q, refresh_q;
  logic [31:0] shown_q, shown_d;
  logic [CountW-1:0] done_q;
  logic        alarm_d, refresh_d;

  logic        accept;
  logic        tick_due;
  logic [CfgW-1:0]   sess_dec;
  logic [CfgW-1:0]   cd_dec;
  logic [CountW-1:0] focus_inc;
  phase_e      adv_phase;
  logic [CfgW-1:0]   adv_len;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_len_q <= FocusRst;
      short_len_q <= ShortRst;
      long_len_q  <= LongRst;
      cd_len_q    <= CountdownRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FOCUS:     focus_len_q <= cfg_data_i;
        REG_SHORT:     short_len_q <= cfg_data_i;
        REG_LONG:      long_len_q  <= cfg_data_i;
        REG_COUNTDOWN: cd_len_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign tick_due  = run_q && ((now_ms_i - last_ms_q) >= TickMs);
  assign sess_dec  = (session_left_q != '0) ? session_left_q - 1'b1 : session_left_q;
  assign cd_dec    = (cd_left_q != '0) ? cd_left_q - 1'b1 : cd_left_q;
  assign focus_inc = focus_cnt_q + 1'b1;

  // phase that follows the current one, and its length
  always_comb begin
    if (phase_q == PHASE_FOCUS) begin
      adv_phase = (focus_inc[$clog2(LongEvery)-1:0] == '0) ? PHASE_LONG : PHASE_SHORT;
    end else begin
      adv_phase = PHASE_FOCUS;
    end
    case (adv_phase)
      PHASE_SHORT: adv_len = short_len_q;
      PHASE_LONG:  adv_len = long_len_q;
      default:     adv_len = focus_len_q;
    endcase
  end

  // event logic
  always_comb begin
    run_d          = run_q;
    mode_d         = mode_q;
    phase_d        = phase_q;
    session_left_d = session_left_q;
    focus_cnt_d    = focus_cnt_q;
    cd_left_d      = cd_left_q;
    elapsed_d      = elapsed_q;
    last_ms_d      = last_ms_q;
    alarm_d        = 1'b0;
    refresh_d      = 1'b0;
    case (func_e'(func_i))
      FUNC_TICK: begin
        if (tick_due) begin
          last_ms_d = now_ms_i;
          refresh_d = 1'b1;
          case (mode_q)
            MODE_SESSION: begin
              session_left_d = sess_dec;
              if (sess_dec == '0) begin
                run_d          = 1'b0;
                alarm_d        = 1'b1;
                phase_d        = adv_phase;
                session_left_d = adv_len;
                if (phase_q == PHASE_FOCUS) begin
                  focus_cnt_d = focus_inc;
                end
              end
            end
            MODE_COUNTDOWN: begin
              cd_left_d = cd_dec;
              if (cd_dec == '0) begin
                run_d   = 1'b0;
                alarm_d = 1'b1;
              end
            end
            default: elapsed_d = elapsed_q + 1'b1;
          endcase
        end
      end
      FUNC_START: begin
        run_d     = 1'b1;
        last_ms_d = now_ms_i;
        refresh_d = 1'b1;
      end
      FUNC_STOP: begin
        run_d     = 1'b0;
        refresh_d = 1'b1;
      end
      FUNC_RESET: begin
        run_d     = 1'b0;
        refresh_d = 1'b1;
        case (mode_q)
          MODE_SESSION: begin
            phase_d        = PHASE_FOCUS;
            session_left_d = focus_len_q;
            focus_cnt_d    = '0;
          end
          MODE_COUNTDOWN: cd_left_d = cd_len_q;
          default:        elapsed_d = '0;
        endcase
      end
      FUNC_NEXT: begin
        run_d          = 1'b0;
        refresh_d      = 1'b1;
        phase_d        = adv_phase;
        session_left_d = adv_len;
        if (phase_q == PHASE_FOCUS) begin
          focus_cnt_d = focus_inc;
        end
      end
      FUNC_MODE: begin
        // a mode code of three is dropped
        if (new_mode_i != 2'd3) begin
          run_d     = 1'b0;
          mode_d    = mode_e'(new_mode_i);
          refresh_d = 1'b1;
        end
      end
      default: ;
    endcase

    case (mode_d)
      MODE_SESSION:   shown_d = {16'd0, session_left_d};
      MODE_COUNTDOWN: shown_d = {16'd0, cd_left_d};
      default:        shown_d = elapsed_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q          <= 1'b0;
      mode_q         <= MODE_SESSION;
      phase_q        <= PHASE_FOCUS;
      session_left_q <= FocusRst;
      focus_cnt_q    <= '0;
      cd_left_q      <= CountdownRst;
      elapsed_q      <= '0;
      last_ms_q      <= '0;
    end else if (accept) begin
      run_q          <= run_d;
      mode_q         <= mode_d;
      phase_q        <= phase_d;
      session_left_q <= session_left_d;
      focus_cnt_q    <= focus_cnt_d;
      cd_left_q      <= cd_left_d;
      elapsed_q      <= elapsed_d;
      last_ms_q      <= last_ms_d;
    end
  end

  // result register
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_out_q  <= mode_d;
      phase_out_q <= phase_d;
      running_q   <= run_d;
      shown_q     <= shown_d;
      done_q      <= focus_cnt_d;
      alarm_q     <= alarm_d;
      refresh_q   <= refresh_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = mode_out_q;
  assign phase_o         = phase_out_q;
  assign running_o       = running_q;
  assign shown_value_o   = shown_q;
  assign sessions_done_o = done_q;
  assign alarm_o         = alarm_q;
  assign refresh_o       = refresh_q;

`ifndef SYNTHESIS
  a_alarm_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_o |-> !running_o && refresh_o)
    else $error("alarm with timer still running or no refresh");

  a_start_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == FUNC_START) |=> out_valid_o && running_o && refresh_o)
    else $error("start transaction did not leave the timer running");

  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no held result");

  a_idle_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept && !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result appeared without an accepted transaction");
`endif

endmodule

FILE: tb/session_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_timer_checker
// Watches the event, result and register ports of the session timer. It keeps
// its own copy of the timer state and register values and works out the
// display each event should produce. It then compares every result
// transaction, field by field, with the oldest expected display.
// ----------------------------------------------------------------------------
module session_timer_checker
  import mmst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         func_i,
  input  logic [StampW-1:0]  now_ms_i,
  input  logic [1:0]         new_mode_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         mode_i,
  input  logic [1:0]         phase_i,
  input  logic               running_i,
  input  logic [31:0]        shown_value_i,
  input  logic [CountW-1:0]  sessions_done_i,
  input  logic               alarm_i,
  input  logic               refresh_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_views_o
);

  typedef struct packed {
    mode_e             mode;
    phase_e            phase;
    logic              running;
    logic [31:0]       shown;
    logic [CountW-1:0] sessions;
    logic              alarm;
    logic              refresh;
  } timer_view_t;

  timer_view_t expected_views[$];

  // register copies
  logic [CfgW-1:0] focus_len, short_len, long_len, countdown_len;

  // timer state copy
  logic              running_q;
  mode_e             mode_q;
  phase_e            phase_q;
  logic [CfgW-1:0]   session_left_q;
  logic [CountW-1:0] focus_count_q;
  logic [CfgW-1:0]   countdown_left_q;
  logic [31:0]       elapsed_q;
  logic [31:0]       last_advance_q;

  function automatic logic [CfgW-1:0] phase_length(input phase_e ph);
    case (ph)
      PHASE_SHORT: return short_len;
      PHASE_LONG:  return long_len;
      default:     return focus_len;
    endcase
  endfunction

  // every fourth completed focus session earns a long break
  task automatic move_to_next_phase();
    if (phase_q == PHASE_FOCUS) begin
      focus_count_q = focus_count_q + 1'b1;
      phase_q = ((focus_count_q % LongEvery) == 0) ? PHASE_LONG : PHASE_SHORT;
    end else begin
      phase_q = PHASE_FOCUS;
    end
    session_left_q = phase_length(phase_q);
    running_q = 1'b0;
  endtask

  task automatic predict_timer_event(input logic [2:0] func, input logic [31:0] now,
                                     input logic [1:0] nm);
    timer_view_t view;
    logic [31:0] gap;
    view = '0;
    gap = now - last_advance_q;
    case (func)
      FUNC_TICK: begin
        if (running_q && gap >= TickMs) begin
          last_advance_q = now;
          view.refresh = 1'b1;
          case (mode_q)
            MODE_SESSION: begin
              if (session_left_q != '0) session_left_q = session_left_q - 1'b1;
              if (session_left_q == '0) begin
                view.alarm = 1'b1;
                move_to_next_phase();
              end
            end
            MODE_COUNTDOWN: begin
              if (countdown_left_q != '0) countdown_left_q = countdown_left_q - 1'b1;
              if (countdown_left_q == '0) begin
                view.alarm = 1'b1;
                running_q = 1'b0;
              end
            end
            default: elapsed_q = elapsed_q + 1'b1;
          endcase
        end
      end
      FUNC_START: begin
        running_q = 1'b1;
        last_advance_q = now;
        view.refresh = 1'b1;
      end
      FUNC_STOP: begin
        running_q = 1'b0;
        view.refresh = 1'b1;
      end
      FUNC_RESET: begin
        running_q = 1'b0;
        case (mode_q)
          MODE_SESSION: begin
            phase_q = PHASE_FOCUS;
            session_left_q = focus_len;
            focus_count_q = '0;
          end
          MODE_COUNTDOWN: countdown_left_q = countdown_len;
          default: elapsed_q = '0;
        endcase
        view.refresh = 1'b1;
      end
      FUNC_NEXT: begin
        move_to_next_phase();
        view.refresh = 1'b1;
      end
      FUNC_MODE: begin
        // mode code three is not a mode and leaves everything alone
        if (nm <= MODE_STOPWATCH) begin
          running_q = 1'b0;
          mode_q = mode_e'(nm);
          view.refresh = 1'b1;
        end
      end
      default: ;
    endcase
    view.mode = mode_q;
    view.phase = phase_q;
    view.running = running_q;
    view.sessions = focus_count_q;
    case (mode_q)
      MODE_SESSION:   view.shown = 32'(session_left_q);
      MODE_COUNTDOWN: view.shown = 32'(countdown_left_q);
      default:        view.shown = elapsed_q;
    endcase
    expected_views.push_back(view);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count_o++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    timer_view_t want;
    if (expected_views.size() == 0) begin
      mismatch_count_o++;
      $display("%0t: result transaction with no event waiting, shown_value %0h",
               $time, shown_value_i);
    end else begin
      want = expected_views.pop_front();
      check_field("mode", 32'(want.mode), 32'(mode_i));
      check_field("phase", 32'(want.phase), 32'(phase_i));
      check_field("running", 32'(want.running), 32'(running_i));
      check_field("shown_value", want.shown, shown_value_i);
      check_field("sessions_done", 32'(want.sessions), 32'(sessions_done_i));
      check_field("alarm", 32'(want.alarm), 32'(alarm_i));
      check_field("refresh", 32'(want.refresh), 32'(refresh_i));
    end
  endtask

  initial mismatch_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_len = FocusRst;
      short_len = ShortRst;
      long_len = LongRst;
      countdown_len = CountdownRst;
      running_q = 1'b0;
      mode_q = MODE_SESSION;
      phase_q = PHASE_FOCUS;
      session_left_q = FocusRst;
      focus_count_q = '0;
      countdown_left_q = CountdownRst;
      elapsed_q = '0;
      last_advance_q = '0;
      expected_views.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      // register writes leave loaded counters alone
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FOCUS:     focus_len = cfg_data_i;
          REG_SHORT:     short_len = cfg_data_i;
          REG_LONG:      long_len = cfg_data_i;
          REG_COUNTDOWN: countdown_len = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_timer_event(func_i, now_ms_i, new_mode_i);
    end
    pending_views_o <= expected_views.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives event transactions and register writes into the session timer. A
// short directed run comes first, then random event streams under several
// register settings and sender and receiver idling patterns. The checker
// beside the block does all the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
  import mmst_pkg::*;
();

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned EventsPerPhase = 166;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         func_i;
  logic [StampW-1:0]  now_ms_i;
  logic [1:0]         new_mode_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         mode_o;
  logic [1:0]         phase_o;
  logic               running_o;
  logic [31:0]        shown_value_o;
  logic [CountW-1:0]  sessions_done_o;
  logic               alarm_o;
  logic               refresh_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  int unsigned mismatch_total;
  int unsigned pending_views;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic [31:0] stamp_ms;

  multi_mode_session_timer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .now_ms_i       (now_ms_i),
    .new_mode_i     (new_mode_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_o         (mode_o),
    .phase_o        (phase_o),
    .running_o      (running_o),
    .shown_value_o  (shown_value_o),
    .sessions_done_o(sessions_done_o),
    .alarm_o        (alarm_o),
    .refresh_o      (refresh_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  session_timer_checker timer_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .func_i          (func_i),
    .now_ms_i        (now_ms_i),
    .new_mode_i      (new_mode_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_i          (mode_o),
    .phase_i         (phase_o),
    .running_i       (running_o),
    .shown_value_i   (shown_value_o),
    .sessions_done_i (sessions_done_o),
    .alarm_i         (alarm_o),
    .refresh_i       (refresh_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_total),
    .pending_views_o (pending_views)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // starts and ends at a falling edge; valid stays high into the next call
  task automatic send_event(input logic [2:0] f, input logic [31:0] stamp,
                            input logic [1:0] nm);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    now_ms_i <= stamp;
    new_mode_i <= nm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly ticks about a second apart, so running timers really count down
  task automatic send_random_event(output bit counts);
    int unsigned roll;
    logic [2:0]  f;
    logic [1:0]  nm;
    logic [31:0] stamp;
    roll = $urandom_range(99);
    nm = 2'($urandom_range(3));
    stamp = $urandom;
    counts = 1'b1;
    if (roll < 55) begin
      f = FUNC_TICK;
      roll = $urandom_range(99);
      if (roll < 75) stamp_ms = stamp_ms + $urandom_range(1000, 1300);
      else if (roll < 95) stamp_ms = stamp_ms + $urandom_range(0, 999);
      else stamp_ms = $urandom;
      stamp = stamp_ms;
    end else if (roll < 68) begin
      f = FUNC_START;
      stamp_ms = stamp_ms + $urandom_range(0, 400);
      stamp = stamp_ms;
    end else if (roll < 73) begin
      f = FUNC_STOP;
    end else if (roll < 78) begin
      f = FUNC_RESET;
    end else if (roll < 84) begin
      f = FUNC_NEXT;
    end else if (roll < 96) begin
      f = FUNC_MODE;
      counts = (nm <= MODE_STOPWATCH);
    end else begin
      f = 3'($urandom_range(6, 7));
      counts = 1'b0;
    end
    send_event(f, stamp, nm);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_views != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_timer_lengths(input logic [CfgW-1:0] focus_s, input logic [CfgW-1:0] short_s,
                                     input logic [CfgW-1:0] long_s, input logic [CfgW-1:0] count_s);
    logic [CfgW-1:0] vals [4];
    vals = '{focus_s, short_s, long_s, count_s};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned done_events;
    bit          counts;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_TICK;
    now_ms_i = '0;
    new_mode_i = MODE_SESSION;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FOCUS;
    cfg_data_i = '0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    stamp_ms = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed run at the reset register values
    send_event(FUNC_TICK, 32'h0000_0000, MODE_SESSION);   // stopped, nothing due
    send_event(FUNC_MODE, 32'hFFFF_FFFF, 2'd3);           // not a mode
    send_event(3'd6, 32'h0000_0000, MODE_SESSION);
    send_event(3'd7, 32'hFFFF_FFFF, 2'd3);
    send_event(FUNC_START, 32'hFFFF_FC00, MODE_SESSION);
    send_event(FUNC_TICK, 32'h0000_0100, MODE_SESSION);   // due across the wrap
    send_event(FUNC_TICK, 32'h0000_0200, MODE_SESSION);   // too early
    send_event(FUNC_TICK, 32'h0000_04E8, MODE_SESSION);   // exactly one second
    send_event(FUNC_STOP, 32'h5555_AAAA, MODE_SESSION);
    send_event(FUNC_NEXT, 32'hAAAA_5555, MODE_SESSION);
    send_event(FUNC_NEXT, 32'h0000_0000, MODE_SESSION);
    send_event(FUNC_RESET, 32'hFFFF_FFFF, MODE_SESSION);
    send_event(FUNC_MODE, 32'h0000_0000, MODE_COUNTDOWN);
    send_event(FUNC_START, 32'h0000_5000, MODE_SESSION);
    send_event(FUNC_TICK, 32'h0000_53E7, MODE_SESSION);
    send_event(FUNC_TICK, 32'h0000_53E8, MODE_SESSION);
    send_event(FUNC_RESET, 32'h0000_0000, MODE_SESSION);
    send_event(FUNC_MODE, 32'h0000_0000, MODE_STOPWATCH);
    send_event(FUNC_START, 32'h0001_0000, MODE_SESSION);
    send_event(FUNC_TICK, 32'h0001_05DC, MODE_SESSION);
    send_event(FUNC_NEXT, 32'h0000_0000, MODE_SESSION);   // phase moves in stopwatch mode
    send_event(FUNC_RESET, 32'h0000_0000, MODE_SESSION);
    send_event(FUNC_MODE, 32'h0000_0000, MODE_SESSION);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        1, 3, 7: write_timer_lengths(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                                     16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)));
        2: write_timer_lengths('0, '0, '0, '0);
        4: write_timer_lengths('1, '1, '1, '1);
        5: write_timer_lengths(16'($urandom_range(1, 8)), 16'($urandom_range(0, 3)),
                               16'($urandom_range(0, 6)), 16'($urandom));
        6: write_timer_lengths(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                               16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
        default: ;
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      done_events = 0;
      while (done_events < EventsPerPhase) begin
        send_random_event(counts);
        if (counts) done_events++;
      end
    end

    drain_results();
    if (mismatch_total == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: multi_mode_session_timer.f
sv/mmst_pkg.sv
sv/multi_mode_session_timer.sv
tb/session_timer_checker.sv
tb/testbench.sv
